/* hw/rtl/ecf_pkg.sv */
// Package for the equal-power cross-fade splicer: default sizes, Q30 constants,
// configuration register indexes and the reciprocal table for the Taylor steps.
// Used by equal_power_crossfade_splicer.sv; depends on nothing.
package ecf_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int SPAN_BITS_DEF       = 24;
    localparam int GAIN_TABLE_BITS_DEF = 8;

    // Q30 datapath widths
    localparam int Q_FRAC     = 30;
    localparam int GAIN_W     = 31;  // holds 0 .. 2^30
    localparam int TH_W       = 31;  // angle below pi/2
    localparam int T2_W       = 32;  // angle squared
    localparam int DIVIDEND_W = 32;
    localparam int RECIP_W    = 33;
    localparam int SHIFT_W    = 6;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int TERM_W     = 4;

    localparam logic [GAIN_W-1:0] GAIN_ONE    = 31'h4000_0000;
    localparam logic [TH_W-1:0]   HALF_PI_Q30 = 31'd1686629713;

    // Series step order: five sine steps, then six cosine steps
    localparam logic [TERM_W-1:0] TERM_SIN_FIRST = 4'd0;
    localparam logic [TERM_W-1:0] TERM_SIN_LAST  = 4'd4;
    localparam logic [TERM_W-1:0] TERM_COS_FIRST = 4'd5;
    localparam logic [TERM_W-1:0] TERM_COS_LAST  = 4'd10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_REQUEST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_MODE   = 2'd2;

    // floor(a / d) == (a * ceil(2^S / d)) >> S for a < 2^32, S = 32 + ceil(log2 d)
    localparam logic [63:0] RECIP_110 = ((64'd1 << 39) + 64'd109) / 64'd110;
    localparam logic [63:0] RECIP_72  = ((64'd1 << 39) + 64'd71) / 64'd72;
    localparam logic [63:0] RECIP_42  = ((64'd1 << 38) + 64'd41) / 64'd42;
    localparam logic [63:0] RECIP_20  = ((64'd1 << 37) + 64'd19) / 64'd20;
    localparam logic [63:0] RECIP_6   = ((64'd1 << 35) + 64'd5) / 64'd6;
    localparam logic [63:0] RECIP_132 = ((64'd1 << 40) + 64'd131) / 64'd132;
    localparam logic [63:0] RECIP_90  = ((64'd1 << 39) + 64'd89) / 64'd90;
    localparam logic [63:0] RECIP_56  = ((64'd1 << 38) + 64'd55) / 64'd56;
    localparam logic [63:0] RECIP_30  = ((64'd1 << 37) + 64'd29) / 64'd30;
    localparam logic [63:0] RECIP_12  = ((64'd1 << 36) + 64'd11) / 64'd12;
    localparam logic [63:0] RECIP_2   = ((64'd1 << 33) + 64'd1) / 64'd2;

    typedef struct packed {
        logic [RECIP_W-1:0] mult;
        logic [SHIFT_W-1:0] shift;
    } t_recip;

    function automatic t_recip recip_entry(input logic [TERM_W-1:0] idx);
        t_recip r;
        case (idx)
            4'd0:    r = '{mult: RECIP_110[RECIP_W-1:0], shift: 6'd39};
            4'd1:    r = '{mult: RECIP_72[RECIP_W-1:0],  shift: 6'd39};
            4'd2:    r = '{mult: RECIP_42[RECIP_W-1:0],  shift: 6'd38};
            4'd3:    r = '{mult: RECIP_20[RECIP_W-1:0],  shift: 6'd37};
            4'd4:    r = '{mult: RECIP_6[RECIP_W-1:0],   shift: 6'd35};
            4'd5:    r = '{mult: RECIP_132[RECIP_W-1:0], shift: 6'd40};
            4'd6:    r = '{mult: RECIP_90[RECIP_W-1:0],  shift: 6'd39};
            4'd7:    r = '{mult: RECIP_56[RECIP_W-1:0],  shift: 6'd38};
            4'd8:    r = '{mult: RECIP_30[RECIP_W-1:0],  shift: 6'd37};
            4'd9:    r = '{mult: RECIP_12[RECIP_W-1:0],  shift: 6'd36};
            4'd10:   r = '{mult: RECIP_2[RECIP_W-1:0],   shift: 6'd33};
            default: r = '{mult: '0, shift: '0};
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/ecf_div.sv */
// Restoring divider for the fade phase: one quotient bit per cycle, MSB first.
// The quotient must fit in QUO_W bits. Depends on nothing.
module ecf_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 24,
    parameter int QUO_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    localparam int DSH_W = DEN_W + QUO_W - 1;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [NUM_W-1:0] r_rem;
    logic [DSH_W-1:0] r_dsh;
    logic [CNT_W-1:0] r_cnt;
    logic [QUO_W-1:0] r_quo;
    logic             r_done;
    logic [NUM_W-1:0] dsh_ext;
    logic [NUM_W-1:0] diff;
    logic             ge;

    always_comb begin
        dsh_ext = NUM_W'(r_dsh);
        ge      = (r_rem >= dsh_ext);
        diff    = r_rem - dsh_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= i_num;
                r_dsh <= DSH_W'(i_den) << (QUO_W - 1);
                r_cnt <= CNT_W'(QUO_W);
            end else if (r_cnt != '0) begin
                if (ge) begin
                    r_rem <= diff;
                end
                r_quo <= {r_quo[QUO_W-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* hw/rtl/equal_power_crossfade_splicer.sv */
// Equal-power cross-fade splicer, top level. Uses ecf_pkg and ecf_div.
// Mixes a segment sample into a source sample with sin/cos weights at span edges.
//
// Each request carries one aligned source/segment pair and yields one mixed
// sample, with tlast on the last sample of the span. One 34x34 multiplier is
// shared under a sequencer; items are processed one at a time. A sample in
// the flat middle of the span (or with no fade) goes from setup and prep
// straight to the two mix passes. A sample in a fade zone first runs the
// bit-serial phase divider (GAIN_TABLE_BITS + 1 iterations), then, unless
// the phase comes out full, 25 multiplier passes for the angle, its square
// and the sine and cosine series, then the two mix passes. The output
// register lets the next request be taken while a result waits downstream.
// Configuration is taken at any time but must only be written while the
// block is idle.
module equal_power_crossfade_splicer #(
    parameter int SAMPLE_BITS     = ecf_pkg::SAMPLE_BITS_DEF,
    parameter int SPAN_BITS       = ecf_pkg::SPAN_BITS_DEF,
    parameter int GAIN_TABLE_BITS = ecf_pkg::GAIN_TABLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // slave side; tdata: source_sample, segment_sample
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     i_s_tdata,
    // master side; tdata: mixed_sample; tlast: span_end
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       o_m_tdata,
    output logic                                   o_m_tlast,
    // configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ecf_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [SPAN_BITS-1:0]                   i_cfg_data
);

    localparam int P_W    = GAIN_TABLE_BITS + 1;
    localparam int NUM_W  = SPAN_BITS + GAIN_TABLE_BITS + 2;
    localparam int ACC_W  = SAMPLE_BITS + 32;
    localparam int MIX_W  = ACC_W - ecf_pkg::Q_FRAC;
    localparam int MUL_W  = ecf_pkg::MUL_W;
    localparam int PROD_W = ecf_pkg::PROD_W;
    localparam int GAIN_W = ecf_pkg::GAIN_W;

    localparam logic signed [MIX_W-1:0] SAT_HI = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [MIX_W-1:0] SAT_LO = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_PREP, S_DIV_GO, S_DIV_WAIT, S_THETA, S_SQUARE,
        S_TERM_MUL, S_TERM_DIV, S_SIN_FIN, S_MIX_SEG, S_MIX_SRC, S_DONE
    } t_state;

    t_state                          r_state;
    logic [SPAN_BITS-1:0]            r_span_length;
    logic [SPAN_BITS-1:0]            r_fade_request;
    logic                            r_erase;
    logic [SPAN_BITS-1:0]            r_pos;
    logic [SPAN_BITS-1:0]            r_len;
    logic [SPAN_BITS-1:0]            r_fade;
    logic [SPAN_BITS-1:0]            r_k;
    logic [SPAN_BITS-1:0]            r_dist;
    logic                            r_last;
    logic signed [SAMPLE_BITS-1:0]   r_src;
    logic signed [SAMPLE_BITS-1:0]   r_seg;
    logic [ecf_pkg::TH_W-1:0]        r_th;
    logic [ecf_pkg::T2_W-1:0]        r_t2;
    logic [ecf_pkg::DIVIDEND_W-1:0]  r_a;
    logic [GAIN_W-1:0]               r_h;
    logic [ecf_pkg::TERM_W-1:0]      r_term;
    logic [GAIN_W-1:0]               r_gseg;
    logic [GAIN_W-1:0]               r_gsrc;
    logic signed [ACC_W-1:0]         r_acc;
    logic                            r_m_tvalid;
    logic [SAMPLE_BITS-1:0]          r_m_data;
    logic                            r_m_tlast;

    // accept-time values
    logic [SPAN_BITS-1:0]            len_eff;
    logic [SPAN_BITS-1:0]            half_len;
    // setup and prep values
    logic [SPAN_BITS-1:0]            len_m1;
    logic                            is_last;
    logic                            head;
    logic                            tail;
    // divider
    logic                            div_start;
    logic [NUM_W-1:0]                div_num;
    logic [SPAN_BITS-1:0]            div_den;
    logic                            div_done;
    logic [P_W-1:0]                  div_quo;
    // shared multiplier
    logic signed [MUL_W-1:0]         mul_a;
    logic signed [MUL_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]        mul_p;
    logic [PROD_W-1:0]               mul_u;
    ecf_pkg::t_recip                 recip;
    logic [PROD_W-1:0]               q_shift;
    logic [ecf_pkg::DIVIDEND_W-1:0]  q_val;
    logic [GAIN_W-1:0]               h_next;
    logic [GAIN_W-1:0]               sin_val;
    logic [GAIN_W-1:0]               gseg_eff;
    // output rounding
    logic signed [ACC_W-1:0]         mix_round;
    logic signed [MIX_W-1:0]         mix_y;
    logic [SAMPLE_BITS-1:0]          mix_sat;
    logic                            out_free;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tlast   = r_m_tlast;

    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[SAMPLE_BITS-1:0] = r_m_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_length  <= SPAN_BITS'(1);
            r_fade_request <= '0;
            r_erase        <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ecf_pkg::CFG_SPAN_LENGTH:  r_span_length  <= i_cfg_data;
                ecf_pkg::CFG_FADE_REQUEST: r_fade_request <= i_cfg_data;
                ecf_pkg::CFG_ERASE_MODE:   r_erase        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        len_eff  = (r_span_length == '0) ? SPAN_BITS'(1) : r_span_length;
        half_len = len_eff >> 1;
        len_m1   = r_len - SPAN_BITS'(1);
        is_last  = (r_pos >= len_m1);
        head     = (r_k < r_fade);
        tail     = (({1'b0, r_k} + {1'b0, r_fade}) >= {1'b0, r_len});
        // phase numerator (2d+1)*2^G + F over 2F
        div_num  = (NUM_W'({r_dist, 1'b1}) << GAIN_TABLE_BITS) + NUM_W'(r_fade);
        div_den  = {r_fade[SPAN_BITS-2:0], 1'b0};
        div_start = (r_state == S_DIV_GO);
    end

    ecf_div #(
        .NUM_W (NUM_W),
        .DEN_W (SPAN_BITS),
        .QUO_W (P_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // operand select for the shared multiplier
    always_comb begin
        recip    = ecf_pkg::recip_entry(r_term);
        gseg_eff = r_erase ? '0 : r_gseg;
        mul_a    = '0;
        mul_b    = '0;
        case (r_state)
            S_THETA: begin
                mul_a = MUL_W'(div_quo);
                mul_b = MUL_W'(ecf_pkg::HALF_PI_Q30);
            end
            S_SQUARE: begin
                mul_a = MUL_W'(r_th);
                mul_b = MUL_W'(r_th);
            end
            S_TERM_MUL: begin
                mul_a = MUL_W'(r_t2);
                mul_b = MUL_W'(r_h);
            end
            S_TERM_DIV: begin
                mul_a = MUL_W'(r_a);
                mul_b = MUL_W'(recip.mult);
            end
            S_SIN_FIN: begin
                mul_a = MUL_W'(r_th);
                mul_b = MUL_W'(r_h);
            end
            S_MIX_SEG: begin
                mul_a = MUL_W'(gseg_eff);
                mul_b = MUL_W'(r_seg);
            end
            S_MIX_SRC: begin
                mul_a = MUL_W'(r_gsrc);
                mul_b = MUL_W'(r_src);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
        mul_u = mul_p;
    end

    always_comb begin
        q_shift = mul_u >> recip.shift;
        q_val   = q_shift[ecf_pkg::DIVIDEND_W-1:0];
        // one minus the scaled term, floored at zero
        h_next  = (q_val >= ecf_pkg::DIVIDEND_W'(ecf_pkg::GAIN_ONE)) ? '0 :
                  ecf_pkg::GAIN_ONE - q_val[GAIN_W-1:0];
        sin_val = mul_u[ecf_pkg::Q_FRAC +: GAIN_W];
        if (sin_val > ecf_pkg::GAIN_ONE) begin
            sin_val = ecf_pkg::GAIN_ONE;
        end
        mix_round = r_acc + (ACC_W'(1) << (ecf_pkg::Q_FRAC - 1));
        mix_y     = mix_round[ACC_W-1:ecf_pkg::Q_FRAC];
        if (mix_y > SAT_HI) begin
            mix_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (mix_y < SAT_LO) begin
            mix_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            mix_sat = mix_y[SAMPLE_BITS-1:0];
        end
        out_free = !r_m_tvalid || i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (r_m_tvalid && i_m_tready && (r_state != S_DONE)) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_src   <= i_s_tdata[SAMPLE_BITS-1:0];
                        r_seg   <= i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                        r_len   <= len_eff;
                        r_fade  <= (r_fade_request > half_len) ? half_len : r_fade_request;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    // clamp a position left past a shortened span to the last sample
                    r_k     <= is_last ? len_m1 : r_pos;
                    r_last  <= is_last;
                    r_pos   <= is_last ? '0 : r_pos + SPAN_BITS'(1);
                    r_gseg  <= ecf_pkg::GAIN_ONE;
                    r_gsrc  <= '0;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_dist  <= head ? r_k : (r_len - SPAN_BITS'(1) - r_k);
                    r_state <= (head || tail) ? S_DIV_GO : S_MIX_SEG;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        // full phase keeps the unity weights
                        r_state <= div_quo[GAIN_TABLE_BITS] ? S_MIX_SEG : S_THETA;
                    end
                end
                S_THETA: begin
                    r_th    <= mul_u[GAIN_TABLE_BITS +: ecf_pkg::TH_W];
                    r_state <= S_SQUARE;
                end
                S_SQUARE: begin
                    r_t2    <= mul_u[ecf_pkg::Q_FRAC +: ecf_pkg::T2_W];
                    r_h     <= ecf_pkg::GAIN_ONE;
                    r_term  <= ecf_pkg::TERM_SIN_FIRST;
                    r_state <= S_TERM_MUL;
                end
                S_TERM_MUL: begin
                    r_a     <= mul_u[ecf_pkg::Q_FRAC +: ecf_pkg::DIVIDEND_W];
                    r_state <= S_TERM_DIV;
                end
                S_TERM_DIV: begin
                    r_h <= h_next;
                    if (r_term == ecf_pkg::TERM_SIN_LAST) begin
                        r_state <= S_SIN_FIN;
                    end else if (r_term == ecf_pkg::TERM_COS_LAST) begin
                        r_gsrc  <= h_next;
                        r_state <= S_MIX_SEG;
                    end else begin
                        r_term  <= r_term + ecf_pkg::TERM_W'(1);
                        r_state <= S_TERM_MUL;
                    end
                end
                S_SIN_FIN: begin
                    r_gseg  <= sin_val;
                    r_h     <= ecf_pkg::GAIN_ONE;
                    r_term  <= ecf_pkg::TERM_COS_FIRST;
                    r_state <= S_TERM_MUL;
                end
                S_MIX_SEG: begin
                    r_acc   <= mul_p[ACC_W-1:0];
                    r_state <= S_MIX_SRC;
                end
                S_MIX_SRC: begin
                    r_acc   <= r_acc + mul_p[ACC_W-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_data   <= mix_sat;
                        r_m_tlast  <= r_last;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
